// ----- sv/tfd_pkg.sv -----
// ----------------------------------------------------------------------------
// tfd_pkg
// Shared types and constants of the trace frame deframer: result codes,
// header word layout and the result record passed from parser to queue.
// ----------------------------------------------------------------------------
package tfd_pkg;

    localparam int unsigned NUM_OPT_WORDS = 5;
    localparam int unsigned NUM_OPT_FLAGS = 6;
    localparam int unsigned MISSING_FLAG  = 7;

    localparam logic [1:0] KIND_HEADER  = 2'd0;
    localparam logic [1:0] KIND_PAYLOAD = 2'd1;
    localparam logic [1:0] KIND_ERROR   = 2'd2;

    localparam logic [7:0] WORD_BYTES = 8'd4;
    localparam logic [2:0] FULL_BYTES = 3'd4;

    typedef struct packed {
        logic [1:0]  kind;
        logic [7:0]  category;
        logic [7:0]  subcategory;
        logic [1:0]  multipart;
        logic [31:0] tick_fast;
        logic [31:0] tick_nano;
        logic [31:0] context_id;
        logic [31:0] program_counter;
        logic [31:0] extra_word;
        logic [31:0] payload_word;
        logic [2:0]  payload_bytes;
        logic        last;
    } res_t;

endpackage

// ----- sv/trace_frame_deframer.sv -----
// Results: a result is written into the queue in the beat of the word that
// completes it and reaches the result ports from the registered head slot;
// words that give no result are absorbed. Throughput: one word per cycle
// while full is low. The result queue holds QUEUE_DEPTH results plus one
// in the head register. Reset: asynchronous, clears the parser to expect a
// frame header and empties the queue.
// ----------------------------------------------------------------------------
// trace_frame_deframer
// Top level: frame parser in front, result queue behind it.
// ----------------------------------------------------------------------------
module trace_frame_deframer #(
    parameter int unsigned QUEUE_DEPTH = 4
) (
    input  logic        clk,
    input  logic        rst_n,
    input  logic        push,
    output logic        full,
    input  logic [31:0] word,
    output logic        empty,
    input  logic        pop,
    output logic [1:0]  kind,
    output logic [7:0]  category,
    output logic [7:0]  subcategory,
    output logic [1:0]  multipart,
    output logic [31:0] tick_fast,
    output logic [31:0] tick_nano,
    output logic [31:0] context_id,
    output logic [31:0] program_counter,
    output logic [31:0] extra_word,
    output logic [31:0] payload_word,
    output logic [2:0]  payload_bytes,
    output logic        last
);

    logic          in_beat;
    logic          res_valid;
    tfd_pkg::res_t res;
    tfd_pkg::res_t head;

    assign in_beat = push && !full;

    tfd_front u_front (
        .clk       (clk),
        .rst_n     (rst_n),
        .in_beat   (in_beat),
        .word      (word),
        .res_valid (res_valid),
        .res       (res)
    );

    tfd_queue #(
        .DEPTH (QUEUE_DEPTH)
    ) u_queue (
        .clk      (clk),
        .rst_n    (rst_n),
        .wr_valid (res_valid),
        .wr_data  (res),
        .full     (full),
        .empty    (empty),
        .pop      (pop),
        .head     (head)
    );

    assign kind            = head.kind;
    assign category        = head.category;
    assign subcategory     = head.subcategory;
    assign multipart       = head.multipart;
    assign tick_fast       = head.tick_fast;
    assign tick_nano       = head.tick_nano;
    assign context_id      = head.context_id;
    assign program_counter = head.program_counter;
    assign extra_word      = head.extra_word;
    assign payload_word    = head.payload_word;
    assign payload_bytes   = head.payload_bytes;
    assign last            = head.last;

`ifndef NO_ASSERTIONS
    a_full_not_empty: assert property (@(posedge clk) disable iff (!rst_n)
        full |-> !empty)
        else $error("queue full while head empty");

    a_error_last: assert property (@(posedge clk) disable iff (!rst_n)
        (!empty && kind == tfd_pkg::KIND_ERROR) |-> (last && payload_bytes == 3'd0))
        else $error("error result not marked last");

    a_payload_bytes: assert property (@(posedge clk) disable iff (!rst_n)
        (!empty && kind == tfd_pkg::KIND_PAYLOAD) |->
        (payload_bytes != 3'd0 && payload_bytes <= tfd_pkg::FULL_BYTES))
        else $error("payload byte count out of range");

    a_result_appears: assert property (@(posedge clk) disable iff (!rst_n)
        (in_beat && res_valid) |=> !empty)
        else $error("result lost after beat");
`endif

endmodule

// ----- sv/tfd_front.sv -----
// ----------------------------------------------------------------------------
// tfd_front
// Frame parser: takes one buffer word per beat, tracks the frame phase,
// captures the optional header words and builds the result record.
// ----------------------------------------------------------------------------
module tfd_front (
    input  logic               clk,
    input  logic               rst_n,
    input  logic               in_beat,
    input  logic [31:0]        word,
    output logic               res_valid,
    output tfd_pkg::res_t      res
);

    typedef enum logic [1:0] {
        PH_HEADER,
        PH_OPTIONS,
        PH_PAYLOAD,
        PH_SKIP
    } phase_t;

    phase_t      phase_reg, phase_next;
    logic [5:0]  pending_reg, pending_next;
    logic [7:0]  left_reg, left_next;
    logic [7:0]  cat_reg, cat_next;
    logic [7:0]  sub_reg, sub_next;
    logic [1:0]  mp_reg, mp_next;
    logic [31:0] opt_reg  [tfd_pkg::NUM_OPT_WORDS];
    logic [31:0] opt_next [tfd_pkg::NUM_OPT_WORDS];

    logic [7:0]  hw_size;
    logic [7:0]  hw_flags;
    logic [2:0]  opt_count;
    logic [4:0]  hdr_bytes;
    logic [8:0]  padded;
    logic [2:0]  low_bit;
    logic [2:0]  take_bytes;
    logic        emit_header;

    always_comb
    begin
        hw_size  = word[7:0];
        hw_flags = word[15:8];
        opt_count = 3'd0;
        for (int i = 0; i < tfd_pkg::NUM_OPT_FLAGS; i++)
        begin
            opt_count = opt_count + {2'b00, hw_flags[i]};
        end
        hdr_bytes = 5'd4 + {opt_count, 2'b00};
        padded    = ({1'b0, hw_size} + 9'd3) & ~9'd3;
        low_bit = 3'd0;
        for (int i = tfd_pkg::NUM_OPT_FLAGS - 1; i >= 0; i--)
        begin
            if (pending_reg[i])
            begin
                low_bit = 3'(i);
            end
        end
        take_bytes = (left_reg < tfd_pkg::WORD_BYTES) ? left_reg[2:0] : tfd_pkg::FULL_BYTES;
    end

    always_comb
    begin
        phase_next   = phase_reg;
        pending_next = pending_reg;
        left_next    = left_reg;
        cat_next     = cat_reg;
        sub_next     = sub_reg;
        mp_next      = mp_reg;
        opt_next     = opt_reg;
        emit_header  = 1'b0;
        res_valid    = 1'b0;
        res          = '0;

        if (in_beat)
        begin
            unique case (phase_reg)
                PH_HEADER:
                begin
                    if (hw_flags[tfd_pkg::MISSING_FLAG] || (hw_size < {3'b000, hdr_bytes}))
                    begin
                        res_valid       = 1'b1;
                        res.kind        = tfd_pkg::KIND_ERROR;
                        res.category    = word[23:16];
                        res.subcategory = word[31:24];
                        res.last        = 1'b1;
                        if (padded > 9'd4)
                        begin
                            left_next  = 8'(padded - 9'd4);
                            phase_next = PH_SKIP;
                        end
                    end
                    else
                    begin
                        cat_next     = word[23:16];
                        sub_next     = word[31:24];
                        mp_next      = 2'd0;
                        left_next    = hw_size - {3'b000, hdr_bytes};
                        pending_next = hw_flags[5:0];
                        for (int i = 0; i < tfd_pkg::NUM_OPT_WORDS; i++)
                        begin
                            opt_next[i] = '0;
                        end
                        if (hw_flags[5:0] != 6'd0)
                        begin
                            phase_next = PH_OPTIONS;
                        end
                        else
                        begin
                            emit_header = 1'b1;
                        end
                    end
                end
                PH_OPTIONS:
                begin
                    if (low_bit == 3'd0)
                    begin
                        mp_next = word[1:0];
                    end
                    else
                    begin
                        opt_next[low_bit - 3'd1] = word;
                    end
                    pending_next = pending_reg & ~(6'd1 << low_bit);
                    if (pending_next == 6'd0)
                    begin
                        emit_header = 1'b1;
                    end
                end
                PH_PAYLOAD:
                begin
                    left_next         = left_reg - {5'b00000, take_bytes};
                    res_valid         = 1'b1;
                    res.kind          = tfd_pkg::KIND_PAYLOAD;
                    res.category      = cat_reg;
                    res.subcategory   = sub_reg;
                    res.multipart     = mp_reg;
                    res.payload_word  = word;
                    res.payload_bytes = take_bytes;
                    res.last          = (left_next == 8'd0);
                    if (left_next == 8'd0)
                    begin
                        phase_next = PH_HEADER;
                    end
                end
                PH_SKIP:
                begin
                    left_next = (left_reg > tfd_pkg::WORD_BYTES) ?
                                left_reg - tfd_pkg::WORD_BYTES : 8'd0;
                    if (left_next == 8'd0)
                    begin
                        phase_next = PH_HEADER;
                    end
                end
                default:
                begin
                    phase_next = PH_HEADER;
                end
            endcase

            if (emit_header)
            begin
                res_valid           = 1'b1;
                res.kind            = tfd_pkg::KIND_HEADER;
                res.category        = cat_next;
                res.subcategory     = sub_next;
                res.multipart       = mp_next;
                res.tick_fast       = opt_next[0];
                res.tick_nano       = opt_next[1];
                res.context_id      = opt_next[2];
                res.program_counter = opt_next[3];
                res.extra_word      = opt_next[4];
                res.last            = (left_next == 8'd0);
                phase_next          = (left_next == 8'd0) ? PH_HEADER : PH_PAYLOAD;
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            phase_reg   <= PH_HEADER;
            pending_reg <= '0;
            left_reg    <= '0;
            cat_reg     <= '0;
            sub_reg     <= '0;
            mp_reg      <= '0;
            for (int i = 0; i < tfd_pkg::NUM_OPT_WORDS; i++)
            begin
                opt_reg[i] <= '0;
            end
        end
        else
        begin
            phase_reg   <= phase_next;
            pending_reg <= pending_next;
            left_reg    <= left_next;
            cat_reg     <= cat_next;
            sub_reg     <= sub_next;
            mp_reg      <= mp_next;
            opt_reg     <= opt_next;
        end
    end

endmodule

// ----- sv/tfd_queue.sv -----
// ----------------------------------------------------------------------------
// tfd_queue
// Result queue: a small memory behind a registered head slot; the head
// slot drives the result ports, with bypass when the memory is empty.
// ----------------------------------------------------------------------------
module tfd_queue #(
    parameter int unsigned DEPTH = 4
) (
    input  logic               clk,
    input  logic               rst_n,
    input  logic               wr_valid,
    input  tfd_pkg::res_t      wr_data,
    output logic               full,
    output logic               empty,
    input  logic               pop,
    output tfd_pkg::res_t      head
);

    localparam int unsigned AW = (DEPTH > 1) ? $clog2(DEPTH) : 1;
    localparam int unsigned CW = $clog2(DEPTH + 1);

    tfd_pkg::res_t mem [DEPTH];
    tfd_pkg::res_t head_reg;
    logic          head_valid_reg;
    logic [AW-1:0] wr_ptr_reg;
    logic [AW-1:0] rd_ptr_reg;
    logic [CW-1:0] count_reg;

    logic take;
    logic mem_empty;
    logic mem_rd;
    logic mem_wr;
    logic bypass;

    assign mem_empty = (count_reg == '0);
    assign take      = !head_valid_reg || pop;
    assign mem_rd    = take && !mem_empty;
    assign bypass    = take && mem_empty && wr_valid;
    assign mem_wr    = wr_valid && !bypass;

    assign full  = (count_reg == CW'(DEPTH));
    assign empty = !head_valid_reg;
    assign head  = head_reg;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            head_valid_reg <= 1'b0;
            wr_ptr_reg     <= '0;
            rd_ptr_reg     <= '0;
            count_reg      <= '0;
        end
        else
        begin
            if (take)
            begin
                head_valid_reg <= mem_rd || bypass;
            end
            if (mem_wr)
            begin
                wr_ptr_reg <= (wr_ptr_reg == AW'(DEPTH - 1)) ? '0 : wr_ptr_reg + 1'b1;
            end
            if (mem_rd)
            begin
                rd_ptr_reg <= (rd_ptr_reg == AW'(DEPTH - 1)) ? '0 : rd_ptr_reg + 1'b1;
            end
            count_reg <= count_reg + CW'(mem_wr) - CW'(mem_rd);
        end
    end

    always_ff @(posedge clk)
    begin
        if (mem_wr)
        begin
            mem[wr_ptr_reg] <= wr_data;
        end
        if (mem_rd)
        begin
            head_reg <= mem[rd_ptr_reg];
        end
        else if (bypass)
        begin
            head_reg <= wr_data;
        end
    end

endmodule

// ----- test/tb_top.sv -----
// ----------------------------------------------------------------------------
// tb_top
// Testbench for trace_frame_deframer. Trace buffer words go in through the
// push/full queue port. A local frame parser predicts each header, payload
// and error beat. A checker pops results under random stalls and compares
// them field by field against the predicted beats. Directed frames cover the
// edge cases. They are followed by randomized frame streams, a drain pause
// and a final back-to-back stretch.
// ----------------------------------------------------------------------------
module tb_top;

    typedef enum logic [1:0] {PH_HEADER, PH_OPTIONS, PH_PAYLOAD, PH_SKIP} parse_phase_t;

    localparam int unsigned IDLE_MAX     = 11;
    localparam int unsigned DRAIN_CYCLES = 8;

    logic        clk   = 1'b0;
    logic        rst_n = 1'b0;
    logic        push  = 1'b0;
    logic [31:0] word  = '0;
    logic        pop   = 1'b0;
    logic        full;
    logic        empty;
    logic [1:0]  kind;
    logic [7:0]  category;
    logic [7:0]  subcategory;
    logic [1:0]  multipart;
    logic [31:0] tick_fast;
    logic [31:0] tick_nano;
    logic [31:0] context_id;
    logic [31:0] program_counter;
    logic [31:0] extra_word;
    logic [31:0] payload_word;
    logic [2:0]  payload_bytes;
    logic        last;

    parse_phase_t   frame_phase = PH_HEADER;
    logic [5:0]     options_due = '0;
    logic [7:0]     bytes_due = '0;
    logic [7:0]     cur_category = '0;
    logic [7:0]     cur_subcategory = '0;
    logic [1:0]     cur_multipart = '0;
    logic [31:0]    option_words [tfd_pkg::NUM_OPT_WORDS];
    tfd_pkg::res_t  predicted_beats [$];
    int unsigned    mismatch_count = 0;
    int unsigned    pop_hold = 0;
    bit             calm = 1'b0;

    trace_frame_deframer dut (
        .clk             (clk),
        .rst_n           (rst_n),
        .push            (push),
        .full            (full),
        .word            (word),
        .empty           (empty),
        .pop             (pop),
        .kind            (kind),
        .category        (category),
        .subcategory     (subcategory),
        .multipart       (multipart),
        .tick_fast       (tick_fast),
        .tick_nano       (tick_nano),
        .context_id      (context_id),
        .program_counter (program_counter),
        .extra_word      (extra_word),
        .payload_word    (payload_word),
        .payload_bytes   (payload_bytes),
        .last            (last)
    );

    initial
    begin
        forever #5 clk = ~clk;
    end

    initial
    begin
        #2_000_000;
        $display("simulation failed");
        $finish;
    end

    function automatic logic [31:0] hdr_word(input logic [7:0] size, input logic [7:0] flags,
                                             input logic [7:0] cat, input logic [7:0] sub);
        return {sub, cat, flags, size};
    endfunction

    function automatic void queue_header();
        tfd_pkg::res_t r;
        r = '0;
        r.kind            = tfd_pkg::KIND_HEADER;
        r.category        = cur_category;
        r.subcategory     = cur_subcategory;
        r.multipart       = cur_multipart;
        r.tick_fast       = option_words[0];
        r.tick_nano       = option_words[1];
        r.context_id      = option_words[2];
        r.program_counter = option_words[3];
        r.extra_word      = option_words[4];
        r.last            = (bytes_due == 0);
        predicted_beats.push_back(r);
        frame_phase = (bytes_due == 0) ? PH_HEADER : PH_PAYLOAD;
    endfunction

    function automatic void deframe_word(input logic [31:0] w);
        tfd_pkg::res_t r;
        int unsigned   hdr_bytes;
        int unsigned   padded;
        int unsigned   n;
        int unsigned   b;
        r = '0;
        case (frame_phase)
            PH_HEADER:
            begin
                hdr_bytes = 4 + 4 * $countones(w[8 +: tfd_pkg::NUM_OPT_FLAGS]);
                if (w[8 + tfd_pkg::MISSING_FLAG] || 32'(w[7:0]) < hdr_bytes)
                begin
                    r.kind        = tfd_pkg::KIND_ERROR;
                    r.category    = w[23:16];
                    r.subcategory = w[31:24];
                    r.last        = 1'b1;
                    predicted_beats.push_back(r);
                    padded = (32'(w[7:0]) + 3) & ~32'd3;
                    if (padded > tfd_pkg::WORD_BYTES)
                    begin
                        bytes_due   = 8'(padded - tfd_pkg::WORD_BYTES);
                        frame_phase = PH_SKIP;
                    end
                end
                else
                begin
                    cur_category    = w[23:16];
                    cur_subcategory = w[31:24];
                    cur_multipart   = '0;
                    foreach (option_words[i])
                        option_words[i] = '0;
                    bytes_due   = 8'(32'(w[7:0]) - hdr_bytes);
                    options_due = w[8 +: tfd_pkg::NUM_OPT_FLAGS];
                    if (options_due != 0)
                        frame_phase = PH_OPTIONS;
                    else
                        queue_header();
                end
            end
            PH_OPTIONS:
            begin
                for (b = 0; b < tfd_pkg::NUM_OPT_FLAGS; b++)
                    if (options_due[b])
                        break;
                if (b == 0)
                    cur_multipart = w[1:0];
                else
                    option_words[b - 1] = w;
                options_due[b] = 1'b0;
                if (options_due == 0)
                    queue_header();
            end
            PH_PAYLOAD:
            begin
                n = (bytes_due < tfd_pkg::WORD_BYTES) ? 32'(bytes_due) :
                    32'(tfd_pkg::WORD_BYTES);
                bytes_due = bytes_due - 8'(n);
                r.kind          = tfd_pkg::KIND_PAYLOAD;
                r.category      = cur_category;
                r.subcategory   = cur_subcategory;
                r.multipart     = cur_multipart;
                r.payload_word  = w;
                r.payload_bytes = 3'(n);
                r.last          = (bytes_due == 0);
                predicted_beats.push_back(r);
                if (bytes_due == 0)
                    frame_phase = PH_HEADER;
            end
            default:
            begin
                bytes_due = (bytes_due > tfd_pkg::WORD_BYTES) ?
                            bytes_due - tfd_pkg::WORD_BYTES : 8'd0;
                if (bytes_due == 0)
                    frame_phase = PH_HEADER;
            end
        endcase
    endfunction

    function automatic void compare_field(input string name, input logic [31:0] exp_v,
                                          input logic [31:0] act_v, inout bit bad);
        if (act_v !== exp_v)
        begin
            if (mismatch_count < 10)
                $display("%0t %s: expected %h, got %h", $time, name, exp_v, act_v);
            bad = 1'b1;
        end
    endfunction

    task automatic check_result();
        tfd_pkg::res_t exp_r;
        bit            bad;
        bad = 1'b0;
        if (predicted_beats.size() == 0)
        begin
            if (mismatch_count < 10)
                $display("%0t unexpected result beat, kind %h", $time, kind);
            mismatch_count++;
            return;
        end
        exp_r = predicted_beats.pop_front();
        compare_field("kind", 32'(exp_r.kind), 32'(kind), bad);
        compare_field("category", 32'(exp_r.category), 32'(category), bad);
        compare_field("subcategory", 32'(exp_r.subcategory), 32'(subcategory), bad);
        compare_field("multipart", 32'(exp_r.multipart), 32'(multipart), bad);
        compare_field("tick_fast", exp_r.tick_fast, tick_fast, bad);
        compare_field("tick_nano", exp_r.tick_nano, tick_nano, bad);
        compare_field("context_id", exp_r.context_id, context_id, bad);
        compare_field("program_counter", exp_r.program_counter, program_counter, bad);
        compare_field("extra_word", exp_r.extra_word, extra_word, bad);
        compare_field("payload_word", exp_r.payload_word, payload_word, bad);
        compare_field("payload_bytes", 32'(exp_r.payload_bytes), 32'(payload_bytes), bad);
        compare_field("last", 32'(exp_r.last), 32'(last), bad);
        if (bad)
            mismatch_count++;
    endtask

    always @(posedge clk)
    begin
        if (rst_n && pop && empty === 1'b0)
            check_result();
        if (calm)
        begin
            pop_hold = 0;
            pop <= 1'b1;
        end
        else if (pop_hold != 0)
        begin
            pop_hold--;
            pop <= 1'b0;
        end
        else if ($urandom_range(0, 3) == 0)
        begin
            pop_hold = $urandom_range(1, IDLE_MAX) - 1;
            pop <= 1'b0;
        end
        else
            pop <= 1'b1;
    end

    task automatic send_word(input logic [31:0] w);
        if (!calm && $urandom_range(0, 3) == 0)
        begin
            push <= 1'b0;
            repeat ($urandom_range(1, IDLE_MAX)) @(posedge clk);
        end
        push <= 1'b1;
        word <= w;
        @(posedge clk);
        while (full !== 1'b0)
            @(posedge clk);
        deframe_word(w);
    endtask

    task automatic wait_drained();
        push <= 1'b0;
        do
            @(posedge clk);
        while (predicted_beats.size() != 0);
    endtask

    function automatic logic [31:0] rand_content();
        case ($urandom_range(0, 7))
            0: return '0;
            1: return '1;
            default: return $urandom;
        endcase
    endfunction

    function automatic logic [31:0] random_header();
        logic [7:0]  flags;
        logic [7:0]  size;
        int unsigned hdr_bytes;
        flags = 8'($urandom) & 8'h7f;
        hdr_bytes = 4 + 4 * $countones(flags[5:0]);
        case ($urandom_range(0, 11))
            0:
            begin
                flags[tfd_pkg::MISSING_FLAG] = 1'b1;
                size = ($urandom_range(0, 3) == 0) ? 8'($urandom) : 8'($urandom_range(0, 24));
            end
            1: size = 8'($urandom_range(0, hdr_bytes - 1));
            2: size = 8'($urandom_range(hdr_bytes, 255));
            3: return $urandom;
            default: size = 8'(hdr_bytes + $urandom_range(0, 12));
        endcase
        return hdr_word(size, flags, 8'($urandom), 8'($urandom));
    endfunction

    task automatic send_random_frame();
        send_word(random_header());
        while (frame_phase != PH_HEADER)
            send_word(rand_content());
    endtask

    task automatic test_directed();
        send_word(hdr_word(8'd4, 8'h00, 8'h00, 8'h00));
        send_word(hdr_word(8'd32, 8'h3f, 8'hff, 8'hff));
        send_word(32'hffff_ffff);
        send_word(32'hffff_ffff);
        send_word(32'h0000_0000);
        send_word(32'h8000_0001);
        send_word(32'h7fff_fffe);
        send_word(32'hffff_ffff);
        send_word(32'hdead_beef);
        send_word(hdr_word(8'd7, 8'h00, 8'h5a, 8'ha5));
        send_word(32'haabb_ccdd);
        send_word(hdr_word(8'd12, 8'h80, 8'h12, 8'h34));
        send_word(32'h1111_1111);
        send_word(32'h2222_2222);
        send_word(hdr_word(8'd3, 8'h01, 8'h01, 8'h02));
        send_word(hdr_word(8'd0, 8'h00, 8'hff, 8'h00));
        send_word(hdr_word(8'd4, 8'h40, 8'h33, 8'h44));
        send_word(hdr_word(8'd13, 8'h22, 8'h80, 8'h01));
        send_word(32'h0123_4567);
        send_word(32'h89ab_cdef);
        send_word(32'hffff_ff99);
    endtask

    task automatic test_random_frames(input int unsigned n_words);
        for (int unsigned sent = 0; sent < n_words; )
        begin
            send_word(random_header());
            sent++;
            while (frame_phase != PH_HEADER)
            begin
                send_word(rand_content());
                sent++;
            end
        end
    endtask

    task automatic test_drain_pause();
        repeat (3)
        begin
            repeat ($urandom_range(2, 5))
                send_random_frame();
            wait_drained();
        end
    endtask

    task automatic test_streaming(input int unsigned n_words);
        calm = 1'b1;
        test_random_frames(n_words);
    endtask

    initial
    begin
        foreach (option_words[i])
            option_words[i] = '0;
        repeat (3) @(posedge clk);
        rst_n <= 1'b1;
        test_directed();
        test_random_frames(380);
        test_drain_pause();
        test_streaming(250);
        wait_drained();
        repeat (DRAIN_CYCLES) @(posedge clk);
        if (mismatch_count == 0 && predicted_beats.size() == 0)
            $display("simulation ok");
        else
            $display("simulation failed");
        $finish;
    end

endmodule

// ----- files.f -----
sv/tfd_pkg.sv
sv/tfd_front.sv
sv/tfd_queue.sv
sv/trace_frame_deframer.sv
test/tb_top.sv
